// ===== design/htfd_pkg.sv =====
package htfd_pkg;

  // CRC-8 used by the sensor: polynomial x^8 + x^5 + x^4 + 1, preset to all ones.
  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;

  // Frame byte positions.
  localparam logic [2:0] POS_TEMP_HI = 3'd0;
  localparam logic [2:0] POS_TEMP_LO = 3'd1;
  localparam logic [2:0] POS_TEMP_CRC = 3'd2;
  localparam logic [2:0] POS_HUM_HI = 3'd3;
  localparam logic [2:0] POS_HUM_LO = 3'd4;
  localparam logic [2:0] POS_HUM_CRC = 3'd5;

  // Result status codes.
  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_TEMP_CRC = 2'd1;
  localparam logic [1:0] STATUS_HUM_CRC = 2'd2;

  // What the framer reports for the byte in the input register.
  typedef struct packed {
    logic        last;          // byte closes a frame
    logic [15:0] temp_raw;
    logic [15:0] raw_humidity;
    logic [1:0]  status;
  } frame_t;

  // One decoded result.
  typedef struct packed {
    logic [15:0]        temp_raw;
    logic [15:0]        raw_humidity;
    logic signed [8:0]  temp_degc;
    logic signed [9:0]  temp_degf;
    logic [6:0]         humidity_pct;
    logic [1:0]         status;
  } result_t;

  // Folds one byte into the running CRC, MSB first.
  function automatic logic [7:0] crc_fold(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] c;
    c = acc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

// ===== design/htfd_framer.sv =====
module htfd_framer (
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  logic [7:0]         data_byte,
  input  logic               frame_first,
  output htfd_pkg::frame_t   frame
);

  logic [2:0]  byte_position;
  logic [2:0]  byte_position_next;
  logic [7:0]  crc_accumulator;
  logic [7:0]  crc_accumulator_next;
  logic [15:0] temp_word;
  logic [15:0] temp_word_next;
  logic [15:0] humidity_word;
  logic [15:0] humidity_word_next;
  logic        temp_crc_bad;
  logic        temp_crc_bad_next;
  logic [2:0]  pos;

  always_comb begin
    // A flagged byte, or a position that should never occur, restarts the frame.
    if (frame_first || (byte_position inside {[3'd6:3'd7]})) begin
      pos = htfd_pkg::POS_TEMP_HI;
    end else begin
      pos = byte_position;
    end

    byte_position_next   = pos + 3'd1;
    crc_accumulator_next = crc_accumulator;
    temp_word_next       = temp_word;
    humidity_word_next   = humidity_word;
    temp_crc_bad_next    = temp_crc_bad;

    case (pos)
      htfd_pkg::POS_TEMP_HI: begin
        temp_crc_bad_next    = 1'b0;
        crc_accumulator_next = htfd_pkg::crc_fold(htfd_pkg::CRC_INIT, data_byte);
        temp_word_next       = {data_byte, 8'h00};
      end
      htfd_pkg::POS_TEMP_LO: begin
        crc_accumulator_next = htfd_pkg::crc_fold(crc_accumulator, data_byte);
        temp_word_next       = {temp_word[15:8], data_byte};
      end
      htfd_pkg::POS_TEMP_CRC: begin
        temp_crc_bad_next = (crc_accumulator != data_byte);
      end
      htfd_pkg::POS_HUM_HI: begin
        crc_accumulator_next = htfd_pkg::crc_fold(htfd_pkg::CRC_INIT, data_byte);
        humidity_word_next   = {data_byte, 8'h00};
      end
      htfd_pkg::POS_HUM_LO: begin
        crc_accumulator_next = htfd_pkg::crc_fold(crc_accumulator, data_byte);
        humidity_word_next   = {humidity_word[15:8], data_byte};
      end
      default: begin
        byte_position_next = htfd_pkg::POS_TEMP_HI;
      end
    endcase

    frame.last         = (pos == htfd_pkg::POS_HUM_CRC);
    frame.temp_raw     = temp_word;
    frame.raw_humidity = humidity_word;
    if (temp_crc_bad) begin
      frame.status = htfd_pkg::STATUS_TEMP_CRC;
    end else if (crc_accumulator != data_byte) begin
      frame.status = htfd_pkg::STATUS_HUM_CRC;
    end else begin
      frame.status = htfd_pkg::STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= htfd_pkg::POS_TEMP_HI;
      crc_accumulator <= htfd_pkg::CRC_INIT;
      temp_word       <= 16'h0000;
      humidity_word   <= 16'h0000;
      temp_crc_bad    <= 1'b0;
    end else if (take) begin
      byte_position   <= byte_position_next;
      crc_accumulator <= crc_accumulator_next;
      temp_word       <= temp_word_next;
      humidity_word   <= humidity_word_next;
      temp_crc_bad    <= temp_crc_bad_next;
    end
  end

endmodule

// ===== design/htfd_scale.sv =====
module htfd_scale (
  input  htfd_pkg::frame_t   frame,
  output htfd_pkg::result_t  result
);

  // Each quotient by 65535 is first estimated as the product shifted by 16,
  // which is low by at most one; the remainder then settles it.
  logic [23:0] cel_prod;
  logic [7:0]  cel_q_est;
  logic [16:0] cel_r_est;
  logic [7:0]  cel_q;
  logic [16:0] cel_r;
  logic [24:0] fah_prod;
  logic [8:0]  fah_q_est;
  logic [16:0] fah_r_est;
  logic [8:0]  fah_q;
  logic [16:0] fah_r;
  logic [22:0] hum_prod;
  logic [6:0]  hum_q_est;
  logic [16:0] hum_r_est;
  logic [6:0]  hum_q;
  logic signed [8:0] cel_base;
  logic signed [9:0] fah_base;
  logic        cel_adj;
  logic        fah_adj;
  logic        ok;

  always_comb begin
    cel_prod  = {8'd0, frame.temp_raw} * 24'd175;
    cel_q_est = cel_prod[23:16];
    cel_r_est = {1'b0, cel_prod[15:0]} + {9'd0, cel_q_est};
    if (cel_r_est >= 17'd65535) begin
      cel_q = cel_q_est + 8'd1;
      cel_r = cel_r_est - 17'd65535;
    end else begin
      cel_q = cel_q_est;
      cel_r = cel_r_est;
    end

    fah_prod  = {9'd0, frame.temp_raw} * 25'd315;
    fah_q_est = fah_prod[24:16];
    fah_r_est = {1'b0, fah_prod[15:0]} + {8'd0, fah_q_est};
    if (fah_r_est >= 17'd65535) begin
      fah_q = fah_q_est + 9'd1;
      fah_r = fah_r_est - 17'd65535;
    end else begin
      fah_q = fah_q_est;
      fah_r = fah_r_est;
    end

    hum_prod  = {7'd0, frame.raw_humidity} * 23'd100;
    hum_q_est = hum_prod[22:16];
    hum_r_est = {1'b0, hum_prod[15:0]} + {10'd0, hum_q_est};
    hum_q     = (hum_r_est >= 17'd65535) ? (hum_q_est + 7'd1) : hum_q_est;

    // Below zero a fractional part means truncation rounds up by one.
    cel_base = $signed({1'b0, cel_q}) - 9'sd45;
    fah_base = $signed({1'b0, fah_q}) - 10'sd49;
    cel_adj  = (cel_q < 8'd45) && (cel_r != 17'd0);
    fah_adj  = (fah_q < 9'd49) && (fah_r != 17'd0);

    ok = (frame.status == htfd_pkg::STATUS_OK);
    result.status       = frame.status;
    result.temp_raw     = ok ? frame.temp_raw : 16'h0000;
    result.raw_humidity = ok ? frame.raw_humidity : 16'h0000;
    result.temp_degc    = ok ? (cel_base + $signed({8'd0, cel_adj})) : 9'sd0;
    result.temp_degf    = ok ? (fah_base + $signed({9'd0, fah_adj})) : 10'sd0;
    result.humidity_pct = ok ? hum_q : 7'd0;
  end

endmodule

// ===== design/humidity_temp_frame_decoder_unit.sv =====
// The closing byte of a frame is held in the input register, and its result then loads into the result register.
// Throughput: one byte beat per cycle; the input stalls only while a finished result waits
// downstream and the byte in the input register closes the next frame.
// Reset (rst, synchronous, active high) empties both registers, restarts the byte count,
// presets the CRC to all ones and clears the assembled words and the CRC flag.
module humidity_temp_frame_decoder_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              data_valid,
  output logic              data_stall,
  input  logic [7:0]        data_byte,
  input  logic              frame_first,
  output logic              result_valid,
  input  logic              result_stall,
  output logic [15:0]       temp_raw,
  output logic [15:0]       raw_humidity,
  output logic signed [8:0] temp_degc,
  output logic signed [9:0] temp_degf,
  output logic [6:0]        humidity_pct,
  output logic [1:0]        status
);

  // Input register: one byte beat waiting for the framer.
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_first;

  htfd_pkg::frame_t  frame;
  htfd_pkg::result_t result;

  logic s1_hold;
  logic s1_take;

  // The framer's state advances whenever the held byte moves on. Only a closing
  // byte needs room in the result register, so all other bytes flow freely.
  assign s1_hold    = s1_valid && frame.last && result_valid && result_stall;
  assign s1_take    = s1_valid && !s1_hold;
  assign data_stall = s1_hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!s1_hold) begin
      s1_valid <= data_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (data_valid && !data_stall) begin
      s1_byte  <= data_byte;
      s1_first <= frame_first;
    end
  end

  htfd_framer u_framer (
    .clk         (clk),
    .rst         (rst),
    .take        (s1_take),
    .data_byte   (s1_byte),
    .frame_first (s1_first),
    .frame       (frame)
  );

  // CRC verdict and the three scalings are computed straight from the framer's
  // word registers, so the result is ready in the same cycle as the closing byte.
  htfd_scale u_scale (
    .frame  (frame),
    .result (result)
  );

  // Result register. It loads only when it is empty or being drained.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_take && frame.last) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take && frame.last) begin
      temp_raw     <= result.temp_raw;
      raw_humidity <= result.raw_humidity;
      temp_degc    <= result.temp_degc;
      temp_degf    <= result.temp_degf;
      humidity_pct <= result.humidity_pct;
      status       <= result.status;
    end
  end

  // A failed CRC must blank every data field.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && (status != htfd_pkg::STATUS_OK) |->
      (temp_raw == 16'h0000) && (raw_humidity == 16'h0000) && (temp_degc == 9'sd0) &&
      (temp_degf == 10'sd0) && (humidity_pct == 7'd0))
    else $error("data fields not cleared on CRC failure");

  // The input is held back only behind a stalled result.
  assert property (@(posedge clk) disable iff (rst)
    data_stall |-> result_valid && result_stall)
    else $error("input stalled without a waiting result");

  // Scaled values stay inside the sensor's range.
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (humidity_pct <= 7'd100) && (temp_degc >= -9'sd45) &&
      (temp_degc <= 9'sd130) && (temp_degf >= -10'sd49) &&
      (temp_degf <= 10'sd266))
    else $error("scaled value out of range");

  // A result that could not be taken is still there in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("stalled result was dropped");

endmodule
